>>> rtl/ssfs_pkg.sv
// shared types and constants for the series store with floor search
// holds command codes, field widths and the controller/datapath interface structs
// no dependencies
package ssfs_pkg;

	localparam int OP_W  = 3;
	localparam int SER_W = 2;
	localparam int KEY_W = 64;
	localparam int IDX_W = 10;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND   = 3'd0,
		OP_FLOOR    = 3'd1,
		OP_INTERVAL = 3'd2,
		OP_RANGE    = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	// where the memory read offset comes from
	typedef enum logic [1:0] {
		SEL_MID   = 2'd0,
		SEL_FIRST = 2'd1,
		SEL_LAST  = 2'd2,
		SEL_ZERO  = 2'd3
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    init;
		logic    step;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    cnt_clr;
		logic    set_full;
		logic    fin;
		logic    use_b;
		logic    latch_fk;
		logic    latch_lk;
		logic    publish;
	} ctl_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            exists;
		logic            full;
		logic            n_zero;
		logic            len_zero;
		logic            store_ok;
	} stat_t;

endpackage

>>> rtl/series_store_floor_search.sv
// work per command: clear, unused codes, an empty range and an append with no compare go
// from dispatch straight to the result; an append compared with the last sample reads it first;
// a non-empty range reads the first key, then the last; a floor or interval search takes s halving
// steps (up to ceil(log2(count+1)), 11 at 1024 entries), each a read at mid, then an update
// one item in flight; a new item is taken the cycle after the result enters the output register
// reset clears the entry counts and handshake state; the key and value memories are not cleared
module series_store_floor_search import ssfs_pkg::*; #(
	parameter int SERIES = 4,
	parameter int DEPTH  = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [OP_W-1:0]         cmd,
	input  logic [SER_W-1:0]        series,
	input  logic signed [KEY_W-1:0] key_a,
	input  logic signed [KEY_W-1:0] key_b,
	input  logic signed [KEY_W-1:0] sample_value,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic                    accepted,
	output logic                    full_res,
	output logic                    found_a,
	output logic [IDX_W-1:0]        index_a,
	output logic                    found_b,
	output logic [IDX_W-1:0]        index_b,
	output logic signed [KEY_W-1:0] first_key,
	output logic signed [KEY_W-1:0] last_key
);

	ctl_t  ctl;
	stat_t stat;

	ssfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	ssfs_dp #(.SERIES(SERIES), .DEPTH(DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (cmd),
		.series       (series),
		.key_a        (key_a),
		.key_b        (key_b),
		.sample_value (sample_value),
		.accepted     (accepted),
		.full_res     (full_res),
		.found_a      (found_a),
		.index_a      (index_a),
		.found_b      (found_b),
		.index_b      (index_b),
		.first_key    (first_key),
		.last_key     (last_key)
	);

endmodule

>>> rtl/ssfs_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ssfs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ssfs_ctrl.sv
// sequencing state machine for append, floor search, interval, range and clear
// depends on ssfs_pkg; drives datapath commands and both handshakes
module ssfs_ctrl import ssfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	input  stat_t stat,
	output ctl_t  ctl
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DISPATCH = 9'b000000010,
		S_APP_CHK  = 9'b000000100,
		S_SRCH     = 9'b000001000,
		S_STEP     = 9'b000010000,
		S_FIN      = 9'b000100000,
		S_RNG1     = 9'b001000000,
		S_RNG2     = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   phase_q, phase_d;
	logic   out_valid_q, out_valid_d;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		out_valid_d = out_valid_q;
		ctl         = '0;
		ctl.rd_sel  = SEL_MID;
		ctl.use_b   = phase_q;
		if (out_valid_q && !rsp_stall) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					phase_d  = 1'b0;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				case (stat.op)
					OP_APPEND: begin
						if (stat.exists && stat.full) begin
							ctl.set_full = 1'b1;
						end else if (stat.exists && stat.n_zero) begin
							ctl.wr_en = 1'b1;
						end else if (stat.exists) begin
							ctl.rd_sel = SEL_LAST;
							state_d    = S_APP_CHK;
						end
					end
					OP_FLOOR, OP_INTERVAL: begin
						ctl.init = 1'b1;
						state_d  = S_SRCH;
					end
					OP_RANGE: begin
						if (!stat.n_zero) begin
							ctl.rd_sel = SEL_ZERO;
							state_d    = S_RNG1;
						end
					end
					OP_CLEAR: begin
						ctl.cnt_clr = stat.exists;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_APP_CHK: begin
				ctl.wr_en = stat.store_ok;
				state_d   = S_DONE;
			end
			S_SRCH: begin
				if (stat.len_zero) begin
					ctl.rd_sel = SEL_FIRST;
					state_d    = S_FIN;
				end else begin
					ctl.rd_sel = SEL_MID;
					state_d    = S_STEP;
				end
			end
			S_STEP: begin
				ctl.step = 1'b1;
				state_d  = S_SRCH;
			end
			S_FIN: begin
				ctl.fin = 1'b1;
				// interval runs a second search for the end key
				if (stat.op == OP_INTERVAL && !phase_q) begin
					phase_d  = 1'b1;
					ctl.init = 1'b1;
					state_d  = S_SRCH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RNG1: begin
				ctl.latch_fk = 1'b1;
				ctl.rd_sel   = SEL_LAST;
				state_d      = S_RNG2;
			end
			S_RNG2: begin
				ctl.latch_lk = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !rsp_stall) begin
					ctl.publish = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

>>> rtl/ssfs_dp.sv
// datapath: command registers, entry counts, key/value memories, search registers,
// result and output registers; depends on ssfs_pkg and ssfs_ram
module ssfs_dp import ssfs_pkg::*; #(
	parameter int SERIES = 4,
	parameter int DEPTH  = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctl_t                    ctl,
	output stat_t                   stat,
	input  logic [OP_W-1:0]         cmd,
	input  logic [SER_W-1:0]        series,
	input  logic signed [KEY_W-1:0] key_a,
	input  logic signed [KEY_W-1:0] key_b,
	input  logic signed [KEY_W-1:0] sample_value,
	output logic                    accepted,
	output logic                    full_res,
	output logic                    found_a,
	output logic [IDX_W-1:0]        index_a,
	output logic                    found_b,
	output logic [IDX_W-1:0]        index_b,
	output logic signed [KEY_W-1:0] first_key,
	output logic signed [KEY_W-1:0] last_key
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int MD  = SERIES * DEPTH;
	localparam int AW  = $clog2(MD);
	localparam int NS  = (SERIES < 4) ? SERIES : 4;

	logic [OP_W-1:0]  op_q;
	logic [SER_W-1:0] series_q;
	logic [KEY_W-1:0] key_a_q, key_b_q, val_q;
	logic [CW-1:0]    cnt_q [NS];
	logic [CW-1:0]    first_q, len_q;

	logic             exists;
	logic [CW-1:0]    n, half, mid, off, idx;
	logic [AW-1:0]    base, raddr, waddr;
	logic [KEY_W-1:0] kd, vd, x;
	logic             lt, eq, f;

	// result fields for the item in flight
	logic             acc_q, full_q, fa_q, fb_q;
	logic [IDX_W-1:0] ia_q, ib_q;
	logic [KEY_W-1:0] fk_q, lk_q;

	assign exists = int'(series_q) < SERIES;

	always_comb begin
		n = '0;
		for (int i = 0; i < NS; i++) begin
			if (series_q == SER_W'(i)) begin
				n = cnt_q[i];
			end
		end
	end

	assign base = AW'(AW'(series_q) * AW'(DEPTH));
	assign half = len_q >> 1;
	assign mid  = first_q + half;

	always_comb begin
		case (ctl.rd_sel)
			SEL_MID:   off = mid;
			SEL_FIRST: off = first_q;
			SEL_LAST:  off = n - CW'(1);
			SEL_ZERO:  off = '0;
			default:   off = '0;
		endcase
	end

	assign raddr = base + AW'(off);
	assign waddr = base + AW'(n);

	ssfs_ram #(.WIDTH(KEY_W), .DEPTH(MD)) u_key_ram (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (waddr),
		.wdata (key_a_q),
		.raddr (raddr),
		.rdata (kd)
	);

	ssfs_ram #(.WIDTH(KEY_W), .DEPTH(MD)) u_val_ram (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (waddr),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (vd)
	);

	assign x  = ctl.use_b ? key_b_q : key_a_q;
	assign lt = $signed(kd) < $signed(x);
	assign eq = (kd == x);

	// floor decision once the lower-bound search has settled
	always_comb begin
		if (first_q == n) begin
			f   = (n != '0);
			idx = n - CW'(1);
		end else if (!eq) begin
			f   = (first_q != '0);
			idx = first_q - CW'(1);
		end else begin
			f   = 1'b1;
			idx = first_q;
		end
	end

	always_comb begin
		stat          = '0;
		stat.op       = op_q;
		stat.exists   = exists;
		stat.full     = (n == CW'(DEPTH));
		stat.n_zero   = (n == '0);
		stat.len_zero = (len_q == '0);
		stat.store_ok = (kd != key_a_q) && (vd != val_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (series_q == SER_W'(i)) begin
					if (ctl.cnt_clr) begin
						cnt_q[i] <= '0;
					end else if (ctl.wr_en) begin
						cnt_q[i] <= cnt_q[i] + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q     <= cmd;
			series_q <= series;
			key_a_q  <= key_a;
			key_b_q  <= key_b;
			val_q    <= sample_value;
			acc_q    <= 1'b0;
			full_q   <= 1'b0;
			fa_q     <= 1'b0;
			fb_q     <= 1'b0;
			ia_q     <= '0;
			ib_q     <= '0;
			fk_q     <= '0;
			lk_q     <= '0;
		end
		if (ctl.init) begin
			first_q <= '0;
			len_q   <= n;
		end else if (ctl.step) begin
			if (lt) begin
				first_q <= mid + CW'(1);
				len_q   <= len_q - half - CW'(1);
			end else begin
				len_q <= half;
			end
		end
		if (ctl.wr_en) begin
			acc_q <= 1'b1;
		end
		if (ctl.set_full) begin
			full_q <= 1'b1;
		end
		if (ctl.fin) begin
			if (ctl.use_b) begin
				fb_q <= f;
				ib_q <= f ? IDX_W'(idx) : '0;
			end else begin
				// interval start falls back to entry 0 on a non-empty series
				fa_q <= f || (op_q == OP_INTERVAL && n != '0);
				ia_q <= f ? IDX_W'(idx) : '0;
			end
		end
		if (ctl.latch_fk) begin
			fk_q <= kd;
		end
		if (ctl.latch_lk) begin
			lk_q <= kd;
		end
		if (ctl.publish) begin
			accepted  <= acc_q;
			full_res  <= full_q;
			found_a   <= fa_q;
			index_a   <= ia_q;
			found_b   <= fb_q;
			index_b   <= ib_q;
			first_key <= fk_q;
			last_key  <= lk_q;
		end
	end

endmodule

>>> rtl/ssfs_chk.sv
// port-level checker for series_store_floor_search, bound to the top level
// depends on ssfs_pkg for field widths
module ssfs_chk import ssfs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input logic             accepted,
	input logic             full_res,
	input logic             found_a,
	input logic [IDX_W-1:0] index_a,
	input logic             found_b
);

	// a stalled result beat stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// one command at a time: busy right after taking a beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a command is in flight");

	a_app_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(accepted && full_res))
		else $error("append both stored and rejected full");

	// a found interval end implies a non-empty series, so the start is valid
	a_interval: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found_b |-> found_a)
		else $error("interval end found without a valid start");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found_a |-> index_a == '0)
		else $error("index reported without a match");

endmodule

bind series_store_floor_search ssfs_chk u_ssfs_chk (.*);

>>> tb/tb_series_store_floor_search.sv
// self-checking testbench for series_store_floor_search: directed corners, mixed random
// traffic and a fill of one series to full, checked against an in-bench scoreboard
// depends on rtl/ssfs_pkg.sv and rtl/series_store_floor_search.sv
module tb_series_store_floor_search;
	timeunit 1ns;
	timeprecision 1ps;

	import ssfs_pkg::*;

	localparam int SERIES_N       = 4;
	localparam int DEPTH_N        = 1024;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 100;

	localparam logic [OP_W-1:0] CMD_RSVD_A = 3'd5;
	localparam logic [OP_W-1:0] CMD_RSVD_B = 3'd6;
	localparam logic [OP_W-1:0] CMD_RSVD_C = 3'd7;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7fff_ffff_ffff_ffff;

	typedef struct {
		logic [OP_W-1:0]         cmd;
		logic [SER_W-1:0]        series;
		logic signed [KEY_W-1:0] key_a;
		logic signed [KEY_W-1:0] key_b;
		logic signed [KEY_W-1:0] sample_value;
	} req_t;

	typedef struct {
		logic                    accepted;
		logic                    full_res;
		logic                    found_a;
		logic [IDX_W-1:0]        index_a;
		logic                    found_b;
		logic [IDX_W-1:0]        index_b;
		logic signed [KEY_W-1:0] first_key;
		logic signed [KEY_W-1:0] last_key;
	} rsp_t;

	class series_floor_scoreboard;
		logic signed [KEY_W-1:0] key_mem [SERIES_N*DEPTH_N];
		logic signed [KEY_W-1:0] val_mem [SERIES_N*DEPTH_N];
		int   count [SERIES_N];
		rsp_t pending_answers [$];
		int   errors;
		int   stored, dup_rejects, full_rejects;
		int   floors, intervals, ranges, clears, unused;

		function new();
			foreach (count[i]) count[i] = 0;
			errors = 0;
			stored = 0; dup_rejects = 0; full_rejects = 0;
			floors = 0; intervals = 0; ranges = 0; clears = 0; unused = 0;
		endfunction

		function int pending_count();
			return pending_answers.size();
		endfunction

		// halving lower-bound search, then step back to the floor entry
		function bit floor_index(int s, int n, logic signed [KEY_W-1:0] x, output int idx);
			int first, len, half, mid, base;
			base = s * DEPTH_N;
			first = 0;
			len = n;
			idx = 0;
			while (len > 0) begin
				half = len >> 1;
				mid = first + half;
				if (key_mem[base+mid] < x) begin
					first = mid + 1;
					len = len - half - 1;
				end else begin
					len = half;
				end
			end
			if (first == n) begin
				if (n == 0)
					return 1'b0;
				idx = n - 1;
				return 1'b1;
			end
			if (key_mem[base+first] != x) begin
				if (first == 0)
					return 1'b0;
				idx = first - 1;
				return 1'b1;
			end
			idx = first;
			return 1'b1;
		endfunction

		function rsp_t answer_for(req_t r);
			rsp_t a;
			int s, n, base, ia, ib;
			bit fa, fb;
			a = '{default: '0};
			s = int'(r.series);
			n = count[s];
			base = s * DEPTH_N;
			ia = 0;
			ib = 0;
			case (r.cmd)
				OP_APPEND: begin
					if (n >= DEPTH_N) begin
						a.full_res = 1'b1;
						full_rejects++;
					end else if (n == 0 || (key_mem[base+n-1] != r.key_a &&
							val_mem[base+n-1] != r.sample_value)) begin
						key_mem[base+n] = r.key_a;
						val_mem[base+n] = r.sample_value;
						count[s] = n + 1;
						a.accepted = 1'b1;
						stored++;
					end else begin
						dup_rejects++;
					end
				end
				OP_FLOOR: begin
					fa = floor_index(s, n, r.key_a, ia);
					a.found_a = fa;
					a.index_a = fa ? IDX_W'(ia) : '0;
					floors++;
				end
				OP_INTERVAL: begin
					fa = floor_index(s, n, r.key_a, ia);
					// start falls back to entry 0 on a non-empty series
					if (!fa && n > 0) begin
						fa = 1'b1;
						ia = 0;
					end
					fb = floor_index(s, n, r.key_b, ib);
					a.found_a = fa;
					a.index_a = fa ? IDX_W'(ia) : '0;
					a.found_b = fb;
					a.index_b = fb ? IDX_W'(ib) : '0;
					intervals++;
				end
				OP_RANGE: begin
					if (n > 0) begin
						a.first_key = key_mem[base];
						a.last_key = key_mem[base+n-1];
					end
					ranges++;
				end
				OP_CLEAR: begin
					count[s] = 0;
					clears++;
				end
				default: unused++;
			endcase
			return a;
		endfunction

		function void note_command(req_t r);
			pending_answers.insert(pending_answers.size(), answer_for(r));
		endfunction

		function void cmp(string name, logic [KEY_W-1:0] exp, logic [KEY_W-1:0] got);
			if (got !== exp) begin
				$error("%s: expected %h, got %h", name, exp, got);
				errors++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp;
			if (pending_answers.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
				return;
			end
			exp = pending_answers.pop_front();
			cmp("accepted", 64'(exp.accepted), 64'(got.accepted));
			cmp("full_res", 64'(exp.full_res), 64'(got.full_res));
			cmp("found_a", 64'(exp.found_a), 64'(got.found_a));
			cmp("index_a", 64'(exp.index_a), 64'(got.index_a));
			cmp("found_b", 64'(exp.found_b), 64'(got.found_b));
			cmp("index_b", 64'(exp.index_b), 64'(got.index_b));
			cmp("first_key", exp.first_key, got.first_key);
			cmp("last_key", exp.last_key, got.last_key);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic [OP_W-1:0]         cmd = '0;
	logic [SER_W-1:0]        series = '0;
	logic signed [KEY_W-1:0] key_a = '0;
	logic signed [KEY_W-1:0] key_b = '0;
	logic signed [KEY_W-1:0] sample_value = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic                    accepted;
	logic                    full_res;
	logic                    found_a;
	logic [IDX_W-1:0]        index_a;
	logic                    found_b;
	logic [IDX_W-1:0]        index_b;
	logic signed [KEY_W-1:0] first_key;
	logic signed [KEY_W-1:0] last_key;

	series_floor_scoreboard model;

	// stimulus-side view of each series: what was sent, not what was stored
	logic signed [KEY_W-1:0] lo_k [SERIES_N];
	logic signed [KEY_W-1:0] hi_k [SERIES_N];
	logic signed [KEY_W-1:0] last_v [SERIES_N];
	bit                      used [SERIES_N];

	int gap_max = 0;
	int burst_left = 0;
	int items_sent = 0;
	int quiet = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int hold_left = 0;
	int tick = 0;

	series_store_floor_search #(
		.SERIES(SERIES_N),
		.DEPTH (DEPTH_N)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.series      (series),
		.key_a       (key_a),
		.key_b       (key_b),
		.sample_value(sample_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.accepted    (accepted),
		.full_res    (full_res),
		.found_a     (found_a),
		.index_a     (index_a),
		.found_b     (found_b),
		.index_b     (index_b),
		.first_key   (first_key),
		.last_key    (last_key)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin : monitor
		req_t cin;
		rsp_t got;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				cin.cmd = cmd;
				cin.series = series;
				cin.key_a = key_a;
				cin.key_b = key_b;
				cin.sample_value = sample_value;
				model.note_command(cin);
			end
			if (rsp_valid && !rsp_stall) begin
				got.accepted = accepted;
				got.full_res = full_res;
				got.found_a = found_a;
				got.index_a = index_a;
				got.found_b = found_b;
				got.index_b = index_b;
				got.first_key = first_key;
				got.last_key = last_key;
				model.check_result(got);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", quiet);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// receiver back-pressure, switching between four patterns: none, random, a fixed duty cycle and random holds
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(30, 250);
		end else begin
			stall_left--;
		end
		tick++;
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= 1'($urandom_range(0, 1));
			2: rsp_stall <= (tick % 5) < 3;
			default: begin
				if (hold_left == 0) begin
					rsp_stall <= !rsp_stall;
					hold_left = $urandom_range(1, 40);
				end else begin
					hold_left--;
				end
			end
		endcase
	end

	function automatic logic [KEY_W-1:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic idle_beats(input int n);
		repeat (n) begin
			@(negedge clk);
			req_valid = 1'b0;
		end
	endtask

	task automatic pace();
		if (gap_max == 0)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_beats($urandom_range(1, gap_max));
			burst_left = $urandom_range(0, 11);
		end
	endtask

	task automatic send_beat(input logic [OP_W-1:0] c, input int s,
			input logic signed [KEY_W-1:0] ka, input logic signed [KEY_W-1:0] kb,
			input logic signed [KEY_W-1:0] v);
		@(negedge clk);
		cmd = c;
		series = SER_W'(s);
		key_a = ka;
		key_b = kb;
		sample_value = v;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		items_sent++;
		if (c == OP_CLEAR)
			used[s] = 1'b0;
		pace();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid = 1'b0;
		while (model.pending_count() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] query_key(input int s);
		logic [KEY_W-1:0] span;
		if (!used[s])
			return rnd64();
		span = hi_k[s] - lo_k[s];
		case ($urandom_range(0, 6))
			0: return rnd64();
			1: return lo_k[s];
			2: return hi_k[s];
			3: return lo_k[s] - 1;
			4: return hi_k[s] + 1;
			default: begin
				if (span == '1)
					return rnd64();
				return lo_k[s] + $signed(rnd64() % (span + 1));
			end
		endcase
	endfunction

	// mostly ascending keys, with some repeats of the last key or value and some wild keys
	task automatic random_append(input int s, input int wild_pct);
		logic signed [KEY_W-1:0] k, v;
		int r;
		bit ascend;
		r = $urandom_range(0, 99);
		v = rnd64();
		ascend = 1'b0;
		if (!used[s]) begin
			k = rnd64();
			k[KEY_W-1 -: 2] = 2'b11;
			lo_k[s] = k;
			hi_k[s] = k;
			used[s] = 1'b1;
		end else if (r < 4) begin
			k = hi_k[s];
		end else if (r < 8) begin
			k = hi_k[s] + $urandom_range(1, 1 << 20);
			v = last_v[s];
			ascend = 1'b1;
		end else if (r < 8 + wild_pct) begin
			k = rnd64();
		end else begin
			k = hi_k[s] + $urandom_range(1, 1 << 20);
			ascend = 1'b1;
		end
		if (ascend && k > hi_k[s])
			hi_k[s] = k;
		last_v[s] = v;
		send_beat(OP_APPEND, s, k, rnd64(), v);
	endtask

	task automatic random_query(input int s);
		case ($urandom_range(0, 2))
			0: send_beat(OP_FLOOR, s, query_key(s), rnd64(), rnd64());
			1: send_beat(OP_INTERVAL, s, query_key(s), query_key(s), rnd64());
			default: send_beat(OP_RANGE, s, rnd64(), rnd64(), rnd64());
		endcase
	endtask

	task automatic directed_corners();
		send_beat(OP_RANGE, 0, KEY_MAX, KEY_MIN, '1);
		send_beat(OP_FLOOR, 0, KEY_MAX, '0, '0);
		send_beat(OP_INTERVAL, 0, KEY_MIN, KEY_MAX, '0);
		send_beat(OP_APPEND, 0, KEY_MIN, '0, '0);
		send_beat(OP_APPEND, 0, KEY_MIN, '0, 64'sd1);   // same key
		send_beat(OP_APPEND, 0, 64'sd5, '0, '0);        // same value
		send_beat(OP_APPEND, 0, -64'sd1, '1, KEY_MAX);
		send_beat(OP_APPEND, 0, KEY_MAX, '0, KEY_MIN);
		send_beat(OP_FLOOR, 0, KEY_MIN, '0, '0);
		send_beat(OP_FLOOR, 0, -64'sd2, '0, '0);
		send_beat(OP_FLOOR, 0, KEY_MAX, '0, '0);
		send_beat(OP_FLOOR, 0, '0, '0, '0);
		send_beat(OP_INTERVAL, 0, KEY_MIN, KEY_MAX, '0);
		send_beat(OP_RANGE, 0, '0, '0, '0);
		send_beat(CMD_RSVD_A, 3, '1, '1, '1);
		send_beat(CMD_RSVD_B, 2, '1, '0, '1);
		send_beat(CMD_RSVD_C, 1, '0, '1, '0);
		send_beat(OP_CLEAR, 0, '1, '1, '1);
		send_beat(OP_RANGE, 0, '0, '0, '0);
		send_beat(OP_APPEND, 1, 64'sd10, '0, 64'sd3);
		send_beat(OP_INTERVAL, 1, 64'sd3, 64'sd20, '0);  // start below every key
		send_beat(OP_INTERVAL, 1, 64'sd20, 64'sd3, '0);  // end below every key
		send_beat(OP_APPEND, 1, -64'sd100, '0, 64'sd7);  // out of order key
		send_beat(OP_FLOOR, 1, '0, '0, '0);
		send_beat(OP_CLEAR, 2, '0, '0, '0);              // already empty
	endtask

	task automatic mixed_traffic(input int n);
		int s, r;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 99) begin
				wait_drained();
				gap_max = (gap_max == 0) ? $urandom_range(1, 8) : 0;
			end
			s = $urandom_range(0, SERIES_N - 1);
			r = $urandom_range(0, 99);
			if (r < 40)
				random_append(s, 15);
			else if (r < 58)
				send_beat(OP_FLOOR, s, query_key(s), rnd64(), rnd64());
			else if (r < 72)
				send_beat(OP_INTERVAL, s, query_key(s), query_key(s), rnd64());
			else if (r < 82)
				send_beat(OP_RANGE, s, rnd64(), rnd64(), rnd64());
			else if (r < 87)
				send_beat(OP_CLEAR, s, rnd64(), rnd64(), rnd64());
			else if (r < 92)
				send_beat(OP_W'($urandom_range(CMD_RSVD_A, CMD_RSVD_C)), s,
					rnd64(), rnd64(), rnd64());
			else
				random_append(s, 0);
		end
	endtask

	// fill one series to its depth with queries mixed in, then hit it a few times while full
	task automatic fill_to_full();
		int tgt, fulls0, r, other, i;
		tgt = $urandom_range(0, SERIES_N - 1);
		send_beat(OP_CLEAR, tgt, rnd64(), rnd64(), rnd64());
		fulls0 = model.full_rejects;
		i = 0;
		while (model.full_rejects < fulls0 + 6) begin
			if (i % 150 == 149)
				gap_max = (gap_max == 0) ? $urandom_range(1, 8) : 0;
			i++;
			r = $urandom_range(0, 99);
			other = (tgt + 1 + $urandom_range(0, SERIES_N - 2)) % SERIES_N;
			if (r < 90)
				random_append(tgt, 1);
			else if (r < 97)
				random_query(tgt);
			else if (r < 98)
				random_append(other, 10);
			else
				random_query(other);
		end
	endtask

	initial begin
		model = new();
		foreach (used[i]) used[i] = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_corners();
		wait_drained();
		mixed_traffic(250);
		wait_drained();
		fill_to_full();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d commands: %0d appends stored, %0d rejected as repeats, %0d full",
			items_sent, model.stored, model.dup_rejects, model.full_rejects);
		$display("%0d floors, %0d intervals, %0d ranges, %0d clears, %0d unused codes",
			model.floors, model.intervals, model.ranges, model.clears, model.unused);
		if (model.errors == 0 && model.pending_count() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
